// ----- hdl/fdq_pkg.sv -----
// ----------------------------------------------------------------------------
// fdq_pkg
// Shared types, constants and boundary tables for the fader quantiser.
// ----------------------------------------------------------------------------
package fdq_pkg;

    localparam int CHANNELS   = 8;
    localparam int NUM_FIELDS = 8;
    localparam int CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    localparam int SAMPLE_W  = 12;
    localparam int LEVEL_W   = 7;
    localparam int SUM_W     = 18;
    localparam int FRAMES_W  = 7;
    localparam int COUNT_W   = 6;
    localparam int GAP_W     = 8;
    localparam int QUOT_W    = SAMPLE_W;
    localparam int REM_W     = SUM_W - QUOT_W;
    localparam int BND_W     = SAMPLE_W + 1;
    localparam int DIV_STEPS = QUOT_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);
    localparam int SRCH_W    = $clog2(LEVEL_W);

    localparam int ADC_FULL   = 4095;
    localparam int LEVEL_TOP  = 127;
    localparam int MAX_FRAMES = 64;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAMES = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_GAP    = CFG_IDX_W'(1);

    localparam logic [FRAMES_W-1:0] FRAMES_RESET = FRAMES_W'(8);
    localparam logic [GAP_W-1:0]    GAP_RESET    = GAP_W'(16);

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample_0;
        logic [SAMPLE_W-1:0] sample_1;
        logic [SAMPLE_W-1:0] sample_2;
        logic [SAMPLE_W-1:0] sample_3;
        logic [SAMPLE_W-1:0] sample_4;
        logic [SAMPLE_W-1:0] sample_5;
        logic [SAMPLE_W-1:0] sample_6;
        logic [SAMPLE_W-1:0] sample_7;
    } sample_frame_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] level_0;
        logic [LEVEL_W-1:0] level_1;
        logic [LEVEL_W-1:0] level_2;
        logic [LEVEL_W-1:0] level_3;
        logic [LEVEL_W-1:0] level_4;
        logic [LEVEL_W-1:0] level_5;
        logic [LEVEL_W-1:0] level_6;
        logic [LEVEL_W-1:0] level_7;
    } level_frame_t;

    typedef logic [0:NUM_FIELDS-1][SAMPLE_W-1:0] sample_vec_t;
    typedef logic [0:NUM_FIELDS-1][LEVEL_W-1:0]  level_vec_t;

    typedef struct packed {
        logic [SUM_W-1:0]    sum;
        logic [SAMPLE_W-1:0] min;
        logic [SAMPLE_W-1:0] max;
        logic [LEVEL_W-1:0]  level;
    } chan_entry_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] mean;
        logic [LEVEL_W-1:0]  level;
        logic [GAP_W-1:0]    gap;
        logic                primed;
    } search_req_t;

    typedef logic [0:LEVEL_TOP][SAMPLE_W-1:0] bound_tab_t;

    function automatic bound_tab_t make_floor_tab();
        bound_tab_t tab;
        for (int l = 0; l <= LEVEL_TOP; l++) begin
            tab[l] = SAMPLE_W'((l * ADC_FULL) / LEVEL_TOP);
        end
        return tab;
    endfunction

    function automatic bound_tab_t make_ceil_tab();
        bound_tab_t tab;
        for (int l = 0; l <= LEVEL_TOP; l++) begin
            tab[l] = SAMPLE_W'((l * ADC_FULL + LEVEL_TOP - 1) / LEVEL_TOP);
        end
        return tab;
    endfunction

    localparam bound_tab_t FLOOR_TAB = make_floor_tab();
    localparam bound_tab_t CEIL_TAB  = make_ceil_tab();

endpackage

// ----- hdl/fdq_divider.sv -----
// ----------------------------------------------------------------------------
// fdq_divider
// Restoring divider, one quotient bit per cycle, for the trimmed mean.
// ----------------------------------------------------------------------------
module fdq_divider
    import fdq_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [SUM_W-1:0]    dividend,
    input  logic [FRAMES_W-1:0] divisor,
    output logic                done,
    output logic [QUOT_W-1:0]   quotient
);

    logic                 busy_reg;
    logic                 busy_next;
    logic                 done_reg;
    logic                 done_next;
    logic [DIV_CNT_W-1:0] step_reg;
    logic [DIV_CNT_W-1:0] step_next;
    logic [REM_W-1:0]     rem_reg;
    logic [QUOT_W-1:0]    shf_reg;
    logic [FRAMES_W-1:0]  dsr_reg;
    logic [REM_W:0]       trial;
    logic [REM_W:0]       diff;
    logic                 ge;

    assign trial = {rem_reg, shf_reg[QUOT_W-1]};
    assign ge    = (trial >= dsr_reg);
    assign diff  = trial - dsr_reg;

    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        done_next = 1'b0;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = DIV_CNT_W'(DIV_STEPS);
        end
        else if (busy_reg)
        begin
            step_next = step_reg - 1'b1;
            if (step_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= dividend[SUM_W-1 -: REM_W];
            shf_reg <= dividend[QUOT_W-1:0];
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
            shf_reg <= {shf_reg[QUOT_W-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = shf_reg;

endmodule

// ----- hdl/fdq_level_search.sv -----
// ----------------------------------------------------------------------------
// fdq_level_search
// Binary search over the level boundary tables, one level bit per cycle,
// giving the plain or the hysteresis level for one mean.
// ----------------------------------------------------------------------------
module fdq_level_search
    import fdq_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  search_req_t        req,
    output logic               done,
    output logic [LEVEL_W-1:0] level
);

    search_req_t         req_reg;
    logic                busy_reg;
    logic                busy_next;
    logic                done_reg;
    logic                done_next;
    logic [SRCH_W-1:0]   step_reg;
    logic [SRCH_W-1:0]   step_next;
    logic [LEVEL_W-1:0]  rise_reg;
    logic [LEVEL_W-1:0]  keep_reg;
    logic [LEVEL_W-1:0]  plain_reg;
    logic [LEVEL_W-1:0]  step_bit;
    logic [LEVEL_W-1:0]  rise_cand;
    logic [LEVEL_W-1:0]  keep_cand;
    logic [LEVEL_W-1:0]  plain_cand;
    logic [SAMPLE_W-1:0] rise_bnd;
    logic [SAMPLE_W-1:0] keep_bnd;
    logic [SAMPLE_W-1:0] plain_bnd;
    logic [BND_W-1:0]    mean_ext;
    logic [BND_W-1:0]    gap_ext;
    logic                rise_ok;
    logic                keep_ok;
    logic                plain_ok;
    logic [LEVEL_W-1:0]  risen;
    logic [LEVEL_W-1:0]  settled;

    assign step_bit   = LEVEL_W'(1) << step_reg;
    assign rise_cand  = rise_reg | step_bit;
    assign keep_cand  = keep_reg | step_bit;
    assign plain_cand = plain_reg | step_bit;
    assign rise_bnd   = FLOOR_TAB[rise_cand];
    assign keep_bnd   = FLOOR_TAB[keep_cand];
    assign plain_bnd  = CEIL_TAB[plain_cand];
    assign mean_ext   = BND_W'(req_reg.mean);
    assign gap_ext    = BND_W'(req_reg.gap);

    assign rise_ok  = (mean_ext >= (BND_W'(rise_bnd) + gap_ext));
    assign keep_ok  = (keep_bnd > SAMPLE_W'(req_reg.gap))
                    ? ((mean_ext + gap_ext) > BND_W'(keep_bnd))
                    : (req_reg.mean != '0);
    assign plain_ok = (req_reg.mean >= plain_bnd);

    assign risen   = (req_reg.level > rise_reg) ? req_reg.level : rise_reg;
    assign settled = (risen < keep_reg) ? risen : keep_reg;

    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        done_next = 1'b0;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = SRCH_W'(LEVEL_W - 1);
        end
        else if (busy_reg)
        begin
            step_next = step_reg - 1'b1;
            if (step_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            req_reg   <= req;
            rise_reg  <= '0;
            keep_reg  <= '0;
            plain_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (rise_ok)
            begin
                rise_reg <= rise_cand;
            end
            if (keep_ok)
            begin
                keep_reg <= keep_cand;
            end
            if (plain_ok)
            begin
                plain_reg <= plain_cand;
            end
        end
    end

    assign done  = done_reg;
    assign level = req_reg.primed ? settled : plain_reg;

endmodule

// ----- hdl/fader_adc_to_cc_quantizer.sv -----
// ----------------------------------------------------------------------------
// fader_adc_to_cc_quantizer
// Trimmed-mean decimator with a hysteresis quantiser for eight fader inputs.
// ----------------------------------------------------------------------------
// One frame is taken at a time. The per-channel sum, minimum, maximum and
// level sit in one single-port channel RAM that is visited channel by channel
// (read, then modify and write back); a frame that does not complete a group
// needs only that pass. A completing frame also runs each channel through the
// serial divider (12 steps, then a done strobe) and the level search (7 steps,
// then a done strobe); the divider is the longer of the two. A new frame is
// accepted while the previous result still waits at the output register.
// ----------------------------------------------------------------------------
module fader_adc_to_cc_quantizer
    import fdq_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  sample_valid,
    output logic                  sample_stall,
    input  sample_frame_t         samples,
    output logic                  level_valid,
    input  logic                  level_stall,
    output level_frame_t          levels,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_READ   = 3'd1;
    localparam logic [2:0] ST_UPDATE = 3'd2;
    localparam logic [2:0] ST_DIV    = 3'd3;
    localparam logic [2:0] ST_SRCH   = 3'd4;
    localparam logic [2:0] ST_DONE   = 3'd5;

    chan_entry_t         chan_ram [0:CHANNELS-1];
    chan_entry_t         mem_q_reg;
    chan_entry_t         mem_wdata;
    logic                mem_we;
    logic                mem_re;

    logic [2:0]          state_reg;
    logic [2:0]          state_next;
    logic [CH_W-1:0]     ch_reg;
    logic [CH_W-1:0]     ch_next;
    logic [COUNT_W-1:0]  frame_count_reg;
    logic [COUNT_W-1:0]  frame_count_next;
    logic                primed_reg;
    logic                primed_next;
    logic                level_valid_reg;
    logic                level_valid_next;
    logic                first_reg;
    logic                final_reg;
    logic [FRAMES_W-1:0] held_reg;
    logic [FRAMES_W-1:0] frames_reg;
    logic [GAP_W-1:0]    gap_reg;

    sample_vec_t         frame_reg;
    chan_entry_t         entry_reg;
    logic [LEVEL_W-1:0]  stage_reg [0:CHANNELS-1];
    level_frame_t        levels_reg;
    level_vec_t          out_vec;

    logic                sample_accept;
    logic                load_out;
    logic                last_ch;
    logic [FRAMES_W-1:0] eff_frames;
    logic [FRAMES_W-1:0] held_now;
    logic                group_end;
    logic [SAMPLE_W-1:0] cur_sample;
    chan_entry_t         upd;
    logic [SUM_W-1:0]    dividend;
    logic [FRAMES_W-1:0] divisor;

    logic                div_start;
    logic                div_done;
    logic [QUOT_W-1:0]   div_quot;
    logic                srch_start;
    logic                srch_done;
    logic [LEVEL_W-1:0]  srch_level;
    search_req_t         srch_req;

    assign sample_stall  = (state_reg != ST_IDLE);
    assign sample_accept = sample_valid && !sample_stall;
    assign cfg_ready     = 1'b1;
    assign level_valid   = level_valid_reg;
    assign levels        = levels_reg;

    assign eff_frames = (frames_reg == '0) ? FRAMES_W'(1)
                      : (frames_reg > FRAMES_W'(MAX_FRAMES)) ? FRAMES_W'(MAX_FRAMES)
                      : frames_reg;
    assign held_now   = FRAMES_W'(frame_count_reg) + FRAMES_W'(1);
    assign group_end  = (held_now >= eff_frames);
    assign last_ch    = (ch_reg == CH_W'(CHANNELS - 1));
    assign cur_sample = frame_reg[ch_reg];

    always_comb
    begin
        upd = mem_q_reg;
        if (first_reg)
        begin
            upd.min = cur_sample;
            upd.max = cur_sample;
            upd.sum = SUM_W'(cur_sample);
        end
        else
        begin
            upd.min = (cur_sample < mem_q_reg.min) ? cur_sample : mem_q_reg.min;
            upd.max = (cur_sample > mem_q_reg.max) ? cur_sample : mem_q_reg.max;
            upd.sum = mem_q_reg.sum + SUM_W'(cur_sample);
        end
        if (held_reg > FRAMES_W'(2))
        begin
            dividend = upd.sum - SUM_W'(upd.min) - SUM_W'(upd.max);
            divisor  = held_reg - FRAMES_W'(2);
        end
        else
        begin
            dividend = upd.sum;
            divisor  = held_reg;
        end
    end

    assign mem_re    = (state_reg == ST_READ);
    assign div_start = (state_reg == ST_UPDATE) && final_reg;
    assign srch_start = (state_reg == ST_DIV) && div_done;
    assign load_out  = (state_reg == ST_DONE) && (!level_valid_reg || !level_stall);

    always_comb
    begin
        mem_we    = 1'b0;
        mem_wdata = upd;
        if ((state_reg == ST_UPDATE) && !final_reg)
        begin
            mem_we = 1'b1;
        end
        else if ((state_reg == ST_SRCH) && srch_done)
        begin
            mem_we          = 1'b1;
            mem_wdata.sum   = '0;
            mem_wdata.min   = entry_reg.min;
            mem_wdata.max   = entry_reg.max;
            mem_wdata.level = srch_level;
        end
    end

    always_comb
    begin
        srch_req.mean   = div_quot;
        srch_req.level  = entry_reg.level;
        srch_req.gap    = gap_reg;
        srch_req.primed = primed_reg;
    end

    always_comb
    begin
        state_next       = state_reg;
        ch_next          = ch_reg;
        frame_count_next = frame_count_reg;
        primed_next      = primed_reg;
        level_valid_next = level_valid_reg && level_stall;
        case (state_reg)
            ST_IDLE:
            begin
                if (sample_accept)
                begin
                    state_next       = ST_READ;
                    ch_next          = '0;
                    frame_count_next = group_end ? '0 : held_now[COUNT_W-1:0];
                end
            end
            ST_READ:
            begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                if (final_reg)
                begin
                    state_next = ST_DIV;
                end
                else if (last_ch)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    ch_next    = ch_reg + 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_SRCH;
                end
            end
            ST_SRCH:
            begin
                if (srch_done)
                begin
                    if (last_ch)
                    begin
                        state_next  = ST_DONE;
                        primed_next = 1'b1;
                    end
                    else
                    begin
                        ch_next    = ch_reg + 1'b1;
                        state_next = ST_READ;
                    end
                end
            end
            ST_DONE:
            begin
                if (load_out)
                begin
                    level_valid_next = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            ch_reg          <= '0;
            frame_count_reg <= '0;
            primed_reg      <= 1'b0;
            level_valid_reg <= 1'b0;
            first_reg       <= 1'b0;
            final_reg       <= 1'b0;
            held_reg        <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            ch_reg          <= ch_next;
            frame_count_reg <= frame_count_next;
            primed_reg      <= primed_next;
            level_valid_reg <= level_valid_next;
            if (sample_accept)
            begin
                first_reg <= (frame_count_reg == '0);
                final_reg <= group_end;
                held_reg  <= held_now;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frames_reg <= FRAMES_RESET;
            gap_reg    <= GAP_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_FRAMES: frames_reg <= cfg_data[FRAMES_W-1:0];
                CFG_GAP:    gap_reg    <= cfg_data[GAP_W-1:0];
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            chan_ram[ch_reg] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_q_reg <= chan_ram[ch_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_accept)
        begin
            frame_reg <= sample_vec_t'(samples);
        end
        if (div_start)
        begin
            entry_reg <= upd;
        end
        if ((state_reg == ST_SRCH) && srch_done)
        begin
            stage_reg[ch_reg] <= srch_level;
        end
        if (load_out)
        begin
            levels_reg <= level_frame_t'(out_vec);
        end
    end

    for (genvar k = 0; k < NUM_FIELDS; k++)
    begin : g_out
        if (k < CHANNELS)
        begin : g_used
            assign out_vec[k] = stage_reg[k];
        end
        else
        begin : g_unused
            assign out_vec[k] = '0;
        end
    end

    fdq_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

    fdq_level_search u_search (
        .clk   (clk),
        .rst_n (rst_n),
        .start (srch_start),
        .req   (srch_req),
        .done  (srch_done),
        .level (srch_level)
    );

    a_accept_starts_pass: assert property (@(posedge clk) disable iff (!rst_n)
        sample_accept |=> (state_reg == ST_READ) && (ch_reg == '0))
        else $error("transaction accepted without starting a channel pass");

    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider finished outside its wait state");

    a_srch_done_in_srch: assert property (@(posedge clk) disable iff (!rst_n)
        srch_done |-> (state_reg == ST_SRCH))
        else $error("level search finished outside its wait state");

    a_done_only_on_group_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) |-> final_reg)
        else $error("result staged on a frame that does not end a group");

    a_result_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(level_valid_reg) |-> $past(state_reg) == ST_DONE)
        else $error("result transaction raised outside the hand-over state");

endmodule

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the fader quantiser.
//
// Fader frames go in over a valid/stall channel and level frames come back
// over another. A scoreboard class keeps its own running sums, minima,
// maxima and hysteresis levels, and predicts each level frame when a group
// of frames completes. The bench starts with a short directed sequence:
// extreme samples, band edges, the widest gap, a zero frame count
// and a frame count changed mid-group. It then runs random phases of
// slowly moving faders with noise and extremes mixed in. Gaps fall at
// random on both sides, and one long receiver hold-off backs the block up.
// ----------------------------------------------------------------------------
module tb;
    import fdq_pkg::*;

    localparam int unsigned RANDOM_ITEMS    = 600;
    localparam int unsigned SETTLE_CYCLES   = 250;
    localparam int unsigned HOLD_OFF_CYCLES = 2000;
    localparam int unsigned STALL_LIMIT     = 20000;
    localparam int unsigned SHOWN_FAULTS    = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = CFG_IDX_W'(3);

    class fader_levels;
        int unsigned  frames_cfg;
        int unsigned  gap_cfg;
        int unsigned  ch_sum [NUM_FIELDS];
        int unsigned  ch_min [NUM_FIELDS];
        int unsigned  ch_max [NUM_FIELDS];
        int unsigned  ch_level [NUM_FIELDS];
        int unsigned  frame_cnt;
        bit           primed;
        level_frame_t levels_due [$];
        int unsigned  faults;

        function new();
            frames_cfg = FRAMES_RESET;
            gap_cfg    = GAP_RESET;
            for (int i = 0; i < NUM_FIELDS; i++)
            begin
                ch_sum[i]   = 0;
                ch_min[i]   = 0;
                ch_max[i]   = 0;
                ch_level[i] = 0;
            end
            frame_cnt = 0;
            primed    = 1'b0;
            faults    = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_FRAMES)
                frames_cfg = data[FRAMES_W-1:0];
            else if (idx == CFG_GAP)
                gap_cfg = data[GAP_W-1:0];
        endfunction

        function int unsigned next_level(int unsigned lvl, int unsigned mean);
            int unsigned up;
            int unsigned down;
            int unsigned thr;
            if (!primed)
                return (mean * LEVEL_TOP) / ADC_FULL;
            while (lvl < LEVEL_TOP)
            begin
                up = ((lvl + 1) * ADC_FULL) / LEVEL_TOP;
                if (mean < up + gap_cfg)
                    break;
                lvl++;
            end
            while (lvl > 0)
            begin
                down = (lvl * ADC_FULL) / LEVEL_TOP;
                thr  = (down > gap_cfg) ? down - gap_cfg : 0;
                if (mean > thr)
                    break;
                lvl--;
            end
            return lvl;
        endfunction

        function void take_frame(sample_frame_t f);
            sample_vec_t s;
            level_vec_t  out;
            int unsigned held;
            int unsigned frames;
            int unsigned sum;
            int unsigned cnt;
            int unsigned mean;
            s = sample_vec_t'(f);
            for (int i = 0; i < NUM_FIELDS && i < CHANNELS; i++)
            begin
                if (frame_cnt == 0)
                begin
                    ch_min[i] = s[i];
                    ch_max[i] = s[i];
                    ch_sum[i] = 0;
                end
                else
                begin
                    if (s[i] < ch_min[i])
                        ch_min[i] = s[i];
                    if (s[i] > ch_max[i])
                        ch_max[i] = s[i];
                end
                ch_sum[i] = (ch_sum[i] + s[i]) % (1 << SUM_W);
            end
            held   = frame_cnt + 1;
            frames = (frames_cfg == 0) ? 1 : (frames_cfg > MAX_FRAMES) ? MAX_FRAMES : frames_cfg;
            if (held < frames)
            begin
                frame_cnt = held % (1 << COUNT_W);
                return;
            end
            out = '0;
            for (int i = 0; i < NUM_FIELDS; i++)
            begin
                if (i < CHANNELS)
                begin
                    sum = ch_sum[i];
                    cnt = held;
                    if (cnt > 2)
                    begin
                        sum = sum - ch_min[i] - ch_max[i];
                        cnt = cnt - 2;
                    end
                    mean = sum / cnt;
                    if (mean > ADC_FULL)
                        mean = ADC_FULL;
                    ch_level[i] = next_level(ch_level[i], mean) % (1 << LEVEL_W);
                    ch_sum[i]   = 0;
                    out[i]      = LEVEL_W'(ch_level[i]);
                end
            end
            levels_due.push_back(level_frame_t'(out));
            frame_cnt = 0;
            primed    = 1'b1;
        endfunction

        function void compare_levels(level_frame_t got);
            level_frame_t want;
            level_vec_t   w;
            level_vec_t   g;
            if (levels_due.size() == 0)
            begin
                faults++;
                if (faults <= SHOWN_FAULTS)
                    $display("level transaction with no frame group pending: %h", got);
                return;
            end
            want = levels_due.pop_front();
            w    = level_vec_t'(want);
            g    = level_vec_t'(got);
            for (int i = 0; i < NUM_FIELDS; i++)
            begin
                if (w[i] !== g[i])
                begin
                    faults++;
                    if (faults <= SHOWN_FAULTS)
                        $display("level_%0d: expected %0d, got %0d", i, w[i], g[i]);
                end
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n        = 1'b0;
    logic                  sample_valid = 1'b0;
    logic                  sample_stall;
    sample_frame_t         samples      = '0;
    logic                  level_valid;
    logic                  level_stall  = 1'b0;
    level_frame_t          levels;
    logic                  cfg_valid    = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index    = CFG_FRAMES;
    logic [CFG_DATA_W-1:0] cfg_data     = '0;

    fader_levels track;
    int          fader_pos [NUM_FIELDS];
    bit          tx_burst;
    bit          rx_burst;
    bit          hold_off_pending;

    fader_adc_to_cc_quantizer i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .samples      (samples),
        .level_valid  (level_valid),
        .level_stall  (level_stall),
        .levels       (levels),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int clamp_adc(int x);
        return (x < 0) ? 0 : (x > ADC_FULL) ? ADC_FULL : x;
    endfunction

    function automatic sample_frame_t uniform_frame(int unsigned value);
        sample_vec_t v;
        for (int i = 0; i < NUM_FIELDS; i++)
            v[i] = SAMPLE_W'(value);
        return sample_frame_t'(v);
    endfunction

    function automatic sample_frame_t next_frame();
        sample_vec_t v;
        int unsigned mode;
        int unsigned band;
        int          g;
        mode = $urandom_range(0, 99);
        g    = int'(track.gap_cfg);
        for (int i = 0; i < NUM_FIELDS; i++)
        begin
            if (mode < 70)
            begin
                if ($urandom_range(0, 19) == 0)
                begin
                    band         = $urandom_range(1, LEVEL_TOP - 1);
                    fader_pos[i] = int'((band * ADC_FULL) / LEVEL_TOP)
                                   + int'($urandom_range(0, 2 * g + 6)) - (g + 3);
                end
                else
                begin
                    fader_pos[i] = fader_pos[i] + int'($urandom_range(0, 16)) - 8;
                end
                fader_pos[i] = clamp_adc(fader_pos[i]);
                v[i] = SAMPLE_W'(clamp_adc(fader_pos[i] + int'($urandom_range(0, 6)) - 3));
            end
            else if (mode < 85)
            begin
                v[i] = SAMPLE_W'($urandom);
            end
            else
            begin
                case ($urandom_range(0, 2))
                    0:       v[i] = '0;
                    1:       v[i] = SAMPLE_W'(ADC_FULL);
                    default: v[i] = SAMPLE_W'($urandom);
                endcase
            end
        end
        return sample_frame_t'(v);
    endfunction

    task automatic send_frame(input sample_frame_t f);
        int unsigned idle;
        idle = tx_burst ? 0 : idle_len();
        if (idle > 0)
        begin
            sample_valid <= 1'b0;
            repeat (idle) @(posedge clk);
        end
        samples      <= f;
        sample_valid <= 1'b1;
        do
            @(posedge clk);
        while (sample_stall !== 1'b0);
        track.take_frame(f);
    endtask

    task automatic settle();
        sample_valid <= 1'b0;
        while (track.levels_due.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_config(input int unsigned frames_val, input int unsigned gap_val,
                              input bit poke_spare);
        logic [CFG_IDX_W-1:0]  idx [3];
        logic [CFG_DATA_W-1:0] dat [3];
        int unsigned           n;
        idx[0] = CFG_FRAMES;
        dat[0] = {1'($urandom_range(0, 1)), FRAMES_W'(frames_val)};
        idx[1] = CFG_GAP;
        dat[1] = GAP_W'(gap_val);
        idx[2] = $urandom_range(0, 1) ? CFG_SPARE_HI : CFG_SPARE_LO;
        dat[2] = CFG_DATA_W'($urandom);
        n      = poke_spare ? 3 : 2;
        for (int k = 0; k < n; k++)
        begin
            cfg_index <= idx[k];
            cfg_data  <= dat[k];
            cfg_valid <= 1'b1;
            do
                @(posedge clk);
            while (cfg_ready !== 1'b1);
            track.write_reg(idx[k], dat[k]);
        end
        cfg_valid <= 1'b0;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && level_valid === 1'b1 && level_stall === 1'b0)
            track.compare_levels(levels);
    end

    initial
    begin
        int unsigned len;
        bit          hold;
        forever
        begin
            if (hold_off_pending)
            begin
                hold_off_pending = 1'b0;
                level_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            else
            begin
                hold = !rx_burst && ($urandom_range(0, 2) == 0);
                level_stall <= hold;
                len = hold ? 1 + idle_len() : $urandom_range(1, 12);
                repeat (len) @(posedge clk);
            end
        end
    end

    initial
    begin
        int unsigned idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((sample_valid && !sample_stall) || (level_valid && !level_stall)
                || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("fader_adc_to_cc_quantizer: mismatch");
        $finish;
    end

    initial
    begin
        sample_vec_t v;
        int unsigned sent;
        int unsigned phase;
        int unsigned frames_val;
        int unsigned gap_val;
        int unsigned eff;
        int unsigned count;
        int unsigned r;
        track = new();
        for (int i = 0; i < NUM_FIELDS; i++)
            fader_pos[i] = $urandom_range(0, ADC_FULL);
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: trimmed group of eight, first level unprimed
        for (int k = 0; k < 8; k++)
        begin
            for (int i = 0; i < NUM_FIELDS; i++)
                v[i] = (k == 0) ? '0 : (k == 1) ? SAMPLE_W'(ADC_FULL) : SAMPLE_W'($urandom);
            send_frame(sample_frame_t'(v));
        end

        // zero frame count acts as one; no gap; hit band edges exactly
        settle();
        set_config(0, 0, 1'b1);
        send_frame(uniform_frame(ADC_FULL));
        send_frame(uniform_frame(0));
        for (int i = 0; i < NUM_FIELDS; i++)
            v[i] = SAMPLE_W'(((5 + 16 * i) * ADC_FULL) / LEVEL_TOP);
        send_frame(sample_frame_t'(v));
        for (int i = 0; i < NUM_FIELDS; i++)
            v[i] = v[i] - SAMPLE_W'(1);
        send_frame(sample_frame_t'(v));

        // pairs without trimming, widest gap, falling thresholds saturate at zero
        settle();
        set_config(2, 255, 1'b0);
        for (int i = 0; i < NUM_FIELDS; i++)
            v[i] = SAMPLE_W'(i * 585);
        send_frame(sample_frame_t'(v));
        send_frame(sample_frame_t'(v));
        send_frame(uniform_frame(0));
        send_frame(uniform_frame(0));

        // shrink the frame count mid-group
        settle();
        set_config(3, 8, 1'b0);
        send_frame(next_frame());
        settle();
        set_config(1, 8, 1'b1);
        send_frame(next_frame());

        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS)
        begin
            r = $urandom_range(0, 9);
            if (phase == 1)
                frames_val = $urandom_range(0, 1) ? MAX_FRAMES : 127;
            else if (phase == 6)
                frames_val = $urandom_range(MAX_FRAMES + 1, 127);
            else if (phase == 4)
                frames_val = 1;
            else if (r == 0)
                frames_val = 0;
            else if (r == 1)
                frames_val = 2;
            else if (r == 2)
                frames_val = 3;
            else
                frames_val = $urandom_range(1, 10);
            r = $urandom_range(0, 9);
            gap_val = (r == 0) ? 0 : (r == 1) ? 255 : $urandom_range(1, 48);
            eff     = (frames_val == 0) ? 1 : (frames_val > MAX_FRAMES) ? MAX_FRAMES : frames_val;
            count   = (eff >= 32) ? 2 * eff + $urandom_range(0, eff) : $urandom_range(20, 50);

            settle();
            set_config(frames_val, gap_val, $urandom_range(0, 3) == 0);
            tx_burst = ($urandom_range(0, 3) == 0);
            rx_burst = ($urandom_range(0, 3) == 0);
            if (phase == 4)
            begin
                // hold the receiver off while frames keep coming
                tx_burst         = 1'b1;
                hold_off_pending = 1'b1;
            end
            repeat (count) send_frame(next_frame());
            sent  += count;
            phase++;
        end

        settle();
        if (track.faults == 0 && track.levels_due.size() == 0)
            $display("fader_adc_to_cc_quantizer: match");
        else
            $display("fader_adc_to_cc_quantizer: mismatch");
        $finish;
    end

endmodule
